[sv/axis_angle_view_rotate_assert.svh]
// Assertion macros for the view rotation block.
`ifndef AXIS_ANGLE_VIEW_ROTATE_ASSERT_SVH
`define AXIS_ANGLE_VIEW_ROTATE_ASSERT_SVH
`ifndef SYNTHESIS
`define AAVR_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("failed");
`define AAVR_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("failed");
`else
`define AAVR_ASSERT_IMPL(label, clk, rst, a, c)
`define AAVR_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[sv/aavr_pkg.sv]
package aavr_pkg;
  localparam int TableLen = 24;
  localparam logic signed [35:0] InvGainQ30 = 36'sd652032874;
  localparam logic signed [35:0] PiQ28 = 36'sd843314857;
  localparam logic signed [35:0] HalfPiQ28 = 36'sd421657428;
  localparam logic signed [35:0] TwoPiQ28 = 36'sd1686629713;
  localparam logic signed [35:0] OneQ30 = 36'sd1073741824;

  typedef logic signed [35:0] cw_t;

  typedef struct packed {
    cw_t  x;
    cw_t  y;
    cw_t  z;
    logic flip;
  } cord_t;

  function automatic cw_t atan_q28(input logic [4:0] i);
    cw_t r;
    r = '0;
    case (i)
      5'd0: r = 36'sd210828714;
      5'd1: r = 36'sd124459457;
      5'd2: r = 36'sd65760959;
      5'd3: r = 36'sd33381290;
      5'd4: r = 36'sd16755422;
      5'd5: r = 36'sd8385879;
      5'd6: r = 36'sd4193963;
      5'd7: r = 36'sd2097109;
      5'd8: r = 36'sd1048571;
      5'd9: r = 36'sd524287;
      5'd10: r = 36'sd262144;
      5'd11: r = 36'sd131072;
      5'd12: r = 36'sd65536;
      5'd13: r = 36'sd32768;
      5'd14: r = 36'sd16384;
      5'd15: r = 36'sd8192;
      5'd16: r = 36'sd4096;
      5'd17: r = 36'sd2048;
      5'd18: r = 36'sd1024;
      5'd19: r = 36'sd512;
      5'd20: r = 36'sd256;
      5'd21: r = 36'sd128;
      5'd22: r = 36'sd64;
      5'd23: r = 36'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

[sv/axis_angle_view_rotate.sv]
// Channel | Direction | Handshake        | Word
// in      | input     | in_valid/in_stall | angle, axis, eye, target
// out     | output    | out_valid/out_stall | new_target_x/y/z
//
// One word enters per cycle unless a valid output is held by out_stall. The
// pipeline is the angle-reduce register, the chain of CORDIC cells, one register
// each, then the sign-fix, product and matrix-entry stages and the dot-product lanes.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on a valid output word freezes the whole pipeline; the last stage acts as
// the output register and in_stall follows out_stall while that stage is full.
module axis_angle_view_rotate #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] angle,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] new_target_x,
  output logic signed [31:0] new_target_y,
  output logic signed [31:0] new_target_z
);
  `include "axis_angle_view_rotate_assert.svh"

  // Steps beyond the arctangent table are dropped, as the table ends there.
  localparam int NS = (CORDIC_STEPS > aavr_pkg::TableLen) ? aavr_pkg::TableLen : CORDIC_STEPS;
  // Stages: 1 angle reduce, NS cells, 1 sign fix, 1 products, 1 entries,
  // 2 in the dot lanes.
  localparam int LAT = NS + 6;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic signed [32:0] vz;
  } side_t;

  logic [LAT-1:0] vld;
  logic           en;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Side data rides along with the CORDIC chain in a plain delay line.
  side_t side_in;
  side_t side [NS+4];
  assign side_in = '{ax: axis_x, ay: axis_y, az: axis_z, ex: eye_x, ey: eye_y,
                     ez: eye_z, vx: 33'(target_x) - 33'(eye_x),
                     vy: 33'(target_y) - 33'(eye_y), vz: 33'(target_z) - 33'(eye_z)};

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int i = 1; i < NS + 4; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // Angle reduction into [-pi/2, pi/2], with a flip flag for the far half.
  aavr_pkg::cw_t a0, a1;
  aavr_pkg::cord_t c0;
  always_comb begin
    a0 = aavr_pkg::cw_t'(angle) <<< 16;
    if (a0 > aavr_pkg::PiQ28) begin
      a0 = a0 - aavr_pkg::TwoPiQ28;
    end else if (a0 < -aavr_pkg::PiQ28) begin
      a0 = a0 + aavr_pkg::TwoPiQ28;
    end
    a1 = a0;
    c0.flip = 1'b0;
    if (a0 > aavr_pkg::HalfPiQ28) begin
      a1 = a0 - aavr_pkg::PiQ28;
      c0.flip = 1'b1;
    end else if (a0 < -aavr_pkg::HalfPiQ28) begin
      a1 = a0 + aavr_pkg::PiQ28;
      c0.flip = 1'b1;
    end
    c0.x = aavr_pkg::InvGainQ30;
    c0.y = '0;
    c0.z = a1;
  end

  aavr_pkg::cord_t chain [NS+1];
  always_ff @(posedge clk) begin
    if (en) begin
      chain[0] <= c0;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_cell
    aavr_cell #(.STEP(g)) u_cell (.clk(clk), .en(en), .d(chain[g]), .q(chain[g+1]));
  end

  // Sign fix, then t = 1 - c. With the flip t reaches about 2, so it needs 33 bits.
  logic signed [31:0] cq, sq;
  logic signed [32:0] tq;
  always_ff @(posedge clk) begin
    if (en) begin
      cq <= chain[NS].flip ? -chain[NS].x[31:0] : chain[NS].x[31:0];
      sq <= chain[NS].flip ? -chain[NS].y[31:0] : chain[NS].y[31:0];
      tq <= chain[NS].flip ? 33'(aavr_pkg::OneQ30 + chain[NS].x)
                           : 33'(aavr_pkg::OneQ30 - chain[NS].x);
    end
  end

  // Axis products: t*a*a terms in two stages, s*a in one.
  side_t sa;
  assign sa = side[NS+1];
  logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [47:0] sxq, syq, szq;
  logic signed [31:0] c1;
  logic signed [32:0] t1;
  always_ff @(posedge clk) begin
    if (en) begin
      pxx <= sa.ax * sa.ax;
      pyy <= sa.ay * sa.ay;
      pzz <= sa.az * sa.az;
      pxy <= sa.ax * sa.ay;
      pxz <= sa.ax * sa.az;
      pyz <= sa.ay * sa.az;
      sxq <= sq * sa.ax;
      syq <= sq * sa.ay;
      szq <= sq * sa.az;
      c1 <= cq;
      t1 <= tq;
    end
  end

  // Entry = round((t*p*q + d*c*2^28 + e*s*r*2^14) / 2^34).
  function automatic logic signed [34:0] rnd(input logic signed [71:0] a);
    logic signed [71:0] b;
    b = (a + (72'sd1 <<< 33)) >>> 34;
    return b[34:0];
  endfunction

  logic signed [71:0] txx, tyy, tzz, txy, txz, tyz, cc, sx, sy, sz;
  always_comb begin
    txx = 72'(t1 * pxx);
    tyy = 72'(t1 * pyy);
    tzz = 72'(t1 * pzz);
    txy = 72'(t1 * pxy);
    txz = 72'(t1 * pxz);
    tyz = 72'(t1 * pyz);
    cc = 72'(c1) <<< 28;
    sx = 72'(sxq) <<< 14;
    sy = 72'(syq) <<< 14;
    sz = 72'(szq) <<< 14;
  end

  logic signed [34:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  always_ff @(posedge clk) begin
    if (en) begin
      m00 <= rnd(txx + cc);
      m01 <= rnd(txy - sz);
      m02 <= rnd(txz + sy);
      m10 <= rnd(txy + sz);
      m11 <= rnd(tyy + cc);
      m12 <= rnd(tyz - sx);
      m20 <= rnd(txz - sy);
      m21 <= rnd(tyz + sx);
      m22 <= rnd(tzz + cc);
    end
  end

  side_t sb;
  assign sb = side[NS+3];

  aavr_dot u_dx (.clk(clk), .en(en), .m0(m00), .m1(m01), .m2(m02), .v0(sb.vx),
                 .v1(sb.vy), .v2(sb.vz), .eye(sb.ex), .q(new_target_x));
  aavr_dot u_dy (.clk(clk), .en(en), .m0(m10), .m1(m11), .m2(m12), .v0(sb.vx),
                 .v1(sb.vy), .v2(sb.vz), .eye(sb.ey), .q(new_target_y));
  aavr_dot u_dz (.clk(clk), .en(en), .m0(m20), .m1(m21), .m2(m22), .v0(sb.vx),
                 .v1(sb.vy), .v2(sb.vz), .eye(sb.ez), .q(new_target_z));

  `AAVR_ASSERT_IMPL(a_stall_out, clk, rst, out_valid && out_stall, in_stall)
  `AAVR_ASSERT_NEXT(a_hold_valid, clk, rst, out_valid && out_stall, out_valid)
  `AAVR_ASSERT_NEXT(a_hold_x, clk, rst, out_valid && out_stall, $stable(new_target_x))
  `AAVR_ASSERT_IMPL(a_free_in, clk, rst, !out_valid, !in_stall)
endmodule

[sv/aavr_cell.sv]
// One CORDIC micro-rotation; the stage index is fixed per cell.
module aavr_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  aavr_pkg::cord_t d,
  output aavr_pkg::cord_t q
);
  aavr_pkg::cw_t dx, dy, at;
  aavr_pkg::cord_t nx;

  always_comb begin
    dx = d.y >>> STEP;
    dy = d.x >>> STEP;
    at = aavr_pkg::atan_q28(5'(STEP));
    nx = d;
    if (!d.z[35]) begin
      nx.x = d.x - dx;
      nx.y = d.y + dy;
      nx.z = d.z - at;
    end else begin
      nx.x = d.x + dx;
      nx.y = d.y - dy;
      nx.z = d.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nx;
    end
  end
endmodule

[sv/aavr_dot.sv]
// One output lane: three products plus the eye term, rounded and saturated.
module aavr_dot (
  input  logic               clk,
  input  logic               en,
  input  logic signed [34:0] m0,
  input  logic signed [34:0] m1,
  input  logic signed [34:0] m2,
  input  logic signed [32:0] v0,
  input  logic signed [32:0] v1,
  input  logic signed [32:0] v2,
  input  logic signed [31:0] eye,
  output logic signed [31:0] q
);
  logic signed [67:0] p0, p1, p2;
  logic signed [31:0] eye_d;
  logic signed [71:0] acc;
  logic signed [47:0] sh;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= m0 * v0;
      p1 <= m1 * v1;
      p2 <= m2 * v2;
      eye_d <= eye;
    end
  end

  always_comb begin
    acc = 72'(p0) + 72'(p1) + 72'(p2) + (72'(eye_d) <<< 24) + 72'sd8388608;
    sh = 48'(acc >>> 24);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sh > 48'sd2147483647) begin
        q <= 32'sh7fffffff;
      end else if (sh < -48'sd2147483648) begin
        q <= 32'sh80000000;
      end else begin
        q <= sh[31:0];
      end
    end
  end
endmodule

[tb/view_rotate_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the view rotation block, predicts each new look-at
// point from the accepted input word and compares it with the output words in order.
module view_rotate_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] angle,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] new_target_x,
  input  logic signed [31:0] new_target_y,
  input  logic signed [31:0] new_target_z,
  output int                 errors,
  output int                 pending,
  output int                 checked
);
  localparam int Steps = 16;
  localparam longint InvGain = 652032874;
  localparam longint Pi = 843314857;
  localparam longint HalfPi = 421657428;
  localparam longint TwoPi = 1686629713;
  localparam longint One = 1073741824;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  point_t rotated_q[$];
  longint arctan[24] = '{210828714, 124459457, 65760959, 33381290, 16755422,
    8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

  // The >>> on a signed longint is a floor shift, as the hardware uses.
  function automatic longint round_q24(longint acc);
    return (acc + (64'sd1 <<< 33)) >>> 34;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic point_t rotate_view(longint ang, longint ax, longint ay, longint az,
                                         longint e[3], longint tg[3]);
    longint a, x, y, z, dx, dy, c, s, t, acc;
    longint ak[3], v[3], m[3][3];
    bit flip;
    point_t p;
    a = ang * 65536;
    flip = 0;
    if (a > Pi) a -= TwoPi;
    else if (a < -Pi) a += TwoPi;
    if (a > HalfPi) begin
      a -= Pi;
      flip = 1;
    end else if (a < -HalfPi) begin
      a += Pi;
      flip = 1;
    end
    x = InvGain;
    y = 0;
    z = a;
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= arctan[i];
      end else begin
        x += dx;
        y -= dy;
        z += arctan[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    t = One - c;
    ak = '{ax, ay, az};
    // Rodrigues matrix: c*I + t*a*a^T + s*[a]x, each entry in Q58.
    for (int r = 0; r < 3; r++) begin
      for (int q = 0; q < 3; q++) begin
        acc = t * ak[r] * ak[q];
        if (r == q) acc += c * (64'sd1 <<< 28);
        m[r][q] = acc;
      end
    end
    m[0][1] -= s * az * 16384;
    m[1][0] += s * az * 16384;
    m[0][2] += s * ay * 16384;
    m[2][0] -= s * ay * 16384;
    m[1][2] -= s * ax * 16384;
    m[2][1] += s * ax * 16384;
    for (int k = 0; k < 3; k++) v[k] = tg[k] - e[k];
    for (int r = 0; r < 3; r++) begin
      acc = e[r] * (64'sd1 <<< 24);
      for (int q = 0; q < 3; q++) acc += round_q24(m[r][q]) * v[q];
      ak[r] = (acc + (64'sd1 <<< 23)) >>> 24;
    end
    p.x = clamp32(ak[0]);
    p.y = clamp32(ak[1]);
    p.z = clamp32(ak[2]);
    return p;
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    checked = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    point_t want;
    longint e[3];
    longint tg[3];
    if (!rst && in_valid && !in_stall) begin
      e = '{eye_x, eye_y, eye_z};
      tg = '{target_x, target_y, target_z};
      rotated_q.push_back(rotate_view(angle, axis_x, axis_y, axis_z, e, tg));
    end
    if (!rst && out_valid && !out_stall) begin
      if (rotated_q.size() == 0) begin
        report_mismatch("unexpected word", new_target_x, 0);
      end else begin
        want = rotated_q.pop_front();
        checked++;
        if (new_target_x !== want.x) report_mismatch("x", new_target_x, want.x);
        if (new_target_y !== want.y) report_mismatch("y", new_target_y, want.y);
        if (new_target_z !== want.z) report_mismatch("z", new_target_z, want.z);
      end
    end
    pending = rotated_q.size();
  end
endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

// Top of the view rotation testbench. It makes the input words and the output
// stall pattern, and the checker beside the block predicts and compares.
// The run starts with directed words covering angle wrap, flip regions, full-scale
// axes and saturation, then about 1700 random words, mostly with sane geometry.
module testbench;
  localparam int Directed = 24;
  localparam int RandomWords = 1700;
  localparam int Drain = 60;
  localparam int WatchLimit = 5000;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [15:0] angle = 0, axis_x = 0, axis_y = 0, axis_z = 0;
  logic signed [31:0] eye_x = 0, eye_y = 0, eye_z = 0;
  logic signed [31:0] target_x = 0, target_y = 0, target_z = 0;
  logic               out_valid;
  logic               out_stall = 1;
  logic signed [31:0] new_target_x, new_target_y, new_target_z;
  int errors, pending, checked;
  int idle_cycles = 0;
  bit sending = 1;

  always #2 clk = ~clk;

  axis_angle_view_rotate dut (.*);

  view_rotate_checker check (.*);

  // Most gaps are short; one in fifteen is long, and runs with no gap are common.
  function automatic int gap_length();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic signed [15:0] axis_part();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // Geometry is mostly moderate so that the rotation is not buried in saturation.
  function automatic logic signed [31:0] coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
    endcase
  endfunction

  task automatic send_word(logic signed [15:0] a, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z,
                           logic signed [31:0] ex, logic signed [31:0] ey,
                           logic signed [31:0] ez, logic signed [31:0] tx,
                           logic signed [31:0] ty, logic signed [31:0] tz);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    angle <= a;
    axis_x <= x;
    axis_y <= y;
    axis_z <= z;
    eye_x <= ex;
    eye_y <= ey;
    eye_z <= ez;
    target_x <= tx;
    target_y <= ty;
    target_z <= tz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Output stall runs independently and is asserted on about three draws in ten.
  always @(posedge clk) begin
    if (!rst) out_stall <= ($urandom_range(0, 9) < 3) ? 1'b1 : 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d words outstanding", pending);
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] dir_angle[Directed];
    dir_angle = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd6434, -16'sd6434, 16'sd12868,
      -16'sd12868, 16'sd6435, -16'sd6435, 16'sd12869, -16'sd12869, 16'sd25736,
      -16'sd25736, 16'sd25737, 16'sd3217, -16'sd3217, 16'sd1, -16'sd1, 16'sd9651,
      -16'sd9651, 16'sd20000, -16'sd20000, 16'sh5555, 16'shaaaa};
    repeat (10) @(posedge clk);
    rst <= 0;
    // Directed words: angle boundaries around pi/2, pi and the wrap, with the
    // axis and position extremes, including words that saturate the output.
    for (int i = 0; i < Directed; i++) begin
      case (i % 4)
        0: send_word(dir_angle[i], 16'sd16384, 0, 0, 0, 0, 0, 32'sd65536, 32'sd131072, 0);
        1: send_word(dir_angle[i], 0, -16'sd16384, 0, 32'sh7fffffff, 32'sh80000000,
                     32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        2: send_word(dir_angle[i], 16'sh7fff, 16'sh8000, 16'sh7fff, 32'sh80000000,
                     32'sh7fffffff, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        default: send_word(dir_angle[i], 16'sd9459, 16'sd9459, -16'sd9459, 32'sd1000,
                           -32'sd5000, 32'sd70000, -32'sd300000, 32'sd400000, 0);
      endcase
    end
    for (int i = 0; i < RandomWords; i++) begin
      send_word(16'($urandom), axis_part(), axis_part(), axis_part(), coord(), coord(),
                coord(), coord(), coord(), coord());
    end
    in_valid <= 0;
    while (pending > 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
    $display("sent %0d directed and %0d random words, %0d results checked",
             Directed, RandomWords, checked);
    if (errors == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches, %0d outstanding", errors, pending);
      $display("testbench failed");
    end
    $finish;
  end
endmodule
